FILE: sv/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the standard clock and reset names.
`define ASSERT_CHK(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/rlsfd_pkg.sv
// Types and constants shared by the run-length serial frame decoder.
package rlsfd_pkg;

  // Runs of more than this many whole bit times are gaps; a gap restarts the frame unless it follows CR.
  localparam int GAP_BIT_COUNT = 10;
  // Bit count width: holds GAP_BIT_COUNT + 1.
  localparam int NB_W = $clog2(GAP_BIT_COUNT + 2);

  localparam int RUN_W    = 16;
  localparam int PERIOD_W = 11;
  localparam int SHIFT_W  = 10;
  localparam int LEFT_W   = 8;
  localparam int CHAR_W   = 7;

  // Result buffer for one command.
  localparam int RES_MAX = 3;
  localparam int RES_IDX_W = 2;

  // Command queue depth.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Framing words, as seen in the shift register with the newest bit on top.
  localparam logic [SHIFT_W-1:0] WORD_STX    = 10'h182;
  localparam logic [SHIFT_W-1:0] WORD_LF     = 10'h10a;
  localparam logic [SHIFT_W-1:0] WORD_CR     = 10'h18d;
  localparam logic [SHIFT_W-1:0] WORD_ETX    = 10'(3 << 2);
  localparam logic [SHIFT_W-1:0] WORD_CR_EARLY = 10'(13 << 3);
  localparam logic [SHIFT_W-1:0] WORD_IDLE   = 10'h000;

  localparam logic [LEFT_W-1:0] LEFT_WORD    = 8'd10;
  localparam logic [LEFT_W-1:0] LEFT_CR_TAIL = 8'd8;
  localparam logic [LEFT_W-1:0] LEFT_ETX     = 8'd99;
  localparam logic [LEFT_W-1:0] LEFT_HUNT    = 8'd255;
  localparam logic [LEFT_W-1:0] LEFT_GAP     = 8'd1;
  localparam logic [LEFT_W-1:0] LEFT_CR_PEEK = 8'd3;

  localparam logic [CHAR_W-1:0] CHAR_CR = 7'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF = 7'h0a;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_RESTART  = 2'd1,
    KIND_COMPLETE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    FS_UNKNOWN       = 4'd0,
    FS_GAP           = 4'd1,
    FS_GAP_START     = 4'd2,
    FS_STX_GAP       = 4'd3,
    FS_STX_GAP_START = 4'd4,
    FS_STX_PSS       = 4'd5,
    FS_LF_PSS        = 4'd6,
    FS_DATA_PSS      = 4'd7,
    FS_CR7           = 4'd8,
    FS_CR_PSS        = 4'd9,
    FS_ETX_P         = 4'd10
  } frame_state_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DRAIN
  } back_state_e;

  // One classified run, handed from the front to the back.
  typedef struct packed {
    logic            gap;
    logic            level;
    logic [NB_W-1:0] nbits;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    kind_e             kind;
  } result_t;

endpackage

FILE: sv/rlsfd_front.sv
// Front end: accepts runs and turns run length into a bit count or a gap.
module rlsfd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rlsfd_pkg::PERIOD_W-1:0]    bit_period_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              level_i,
  input  logic [rlsfd_pkg::RUN_W-1:0]       run_length_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output rlsfd_pkg::cmd_t                   cmd_o
);
  import rlsfd_pkg::*;

  front_state_e     state_q, state_d;
  logic [RUN_W-1:0] rem_q, rem_d;
  logic [NB_W-1:0]  cnt_q, cnt_d;
  logic             level_q, level_d;
  logic             gap_q, gap_d;
  logic [RUN_W-1:0] period_ext;
  logic [RUN_W-1:0] rem_sub;

  assign period_ext = RUN_W'(bit_period_i);
  assign rem_sub    = rem_q - period_ext;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the divide loop.
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    level_q <= level_d;
    gap_q   <= gap_d;
  end

  // The quotient is found by repeated subtraction, one per cycle, and the
  // loop stops, flagging a gap, when the count has reached the gap threshold and a period remains.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    gap_d       = gap_q;
    in_ready_o  = 1'b0;
    cmd_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rem_d   = run_length_i;
          cnt_d   = '0;
          level_d = level_i;
          gap_d   = 1'b0;
          // With decoding off the run is dropped here.
          if (bit_period_i >= PERIOD_W'(2)) begin
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (rem_q >= period_ext) begin
          if (cnt_q == NB_W'(GAP_BIT_COUNT)) begin
            gap_d   = 1'b1;
            state_d = F_PUSH;
          end else begin
            rem_d = rem_sub;
            cnt_d = cnt_q + NB_W'(1);
          end
        end else begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign cmd_o = '{gap: gap_q, level: level_q, nbits: cnt_q};

endmodule

FILE: sv/rlsfd_queue.sv
// Short command queue between the front end and the back end.
module rlsfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  rlsfd_pkg::cmd_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output rlsfd_pkg::cmd_t rd_data_o
);
  import rlsfd_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: sv/rlsfd_back.sv
// Back end: shifts bits one per cycle, runs the frame state machine, emits results.
module rlsfd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  rlsfd_pkg::cmd_t                  cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rlsfd_pkg::CHAR_W-1:0]     char_code_o,
  output logic [1:0]                       kind_o,
  output logic                             last_o
);
  import rlsfd_pkg::*;

  back_state_e          state_q, state_d;
  frame_state_e         fs_q, fs_d;
  logic [SHIFT_W-1:0]   shift_q, shift_d;
  logic [LEFT_W-1:0]    left_q, left_d;
  logic [NB_W-1:0]      nb_q, nb_d;
  logic                 level_q, level_d;
  result_t              buf_q [RES_MAX];
  result_t              buf_d [RES_MAX];
  logic [RES_IDX_W-1:0] cnt_q, cnt_d;
  logic [RES_IDX_W-1:0] rd_q, rd_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;
  logic                 last_q, last_d;

  logic [SHIFT_W-1:0]   step_shift;
  logic [LEFT_W-1:0]    step_left;
  logic                 out_free;

  assign step_shift = {level_q, shift_q[SHIFT_W-1:1]};
  assign step_left  = left_q - LEFT_W'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  // Control and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      fs_q        <= FS_UNKNOWN;
      shift_q     <= '0;
      left_q      <= LEFT_HUNT;
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fs_q        <= fs_d;
      shift_q     <= shift_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    nb_q    <= nb_d;
    level_q <= level_d;
    buf_q   <= buf_d;
    out_q   <= out_d;
    last_q  <= last_d;
  end

  // Sequencer: take a command, run its bit steps (none for a gap), then drain any results.
  always_comb begin
    state_d     = state_q;
    fs_d        = fs_q;
    shift_d     = shift_q;
    left_d      = left_q;
    nb_d        = nb_q;
    level_d     = level_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    last_d      = last_q;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          nb_d    = cmd_i.nbits;
          level_d = cmd_i.level;
          if (cmd_i.gap) begin
            // A gap after CR is the pause before ETX; any other gap restarts.
            shift_d = '0;
            left_d  = LEFT_GAP;
            if (fs_q == FS_CR7) begin
              fs_d = FS_STX_GAP;
            end else begin
              fs_d     = FS_GAP;
              buf_d[0] = '{char_code: '0, kind: KIND_RESTART};
              cnt_d    = RES_IDX_W'(1);
              state_d  = B_DRAIN;
            end
          end else if (cmd_i.nbits != '0) begin
            state_d = B_EXEC;
          end
        end
      end

      B_EXEC: begin
        if (nb_q == '0) begin
          state_d = (cnt_q != '0) ? B_DRAIN : B_IDLE;
        end else begin
          nb_d    = nb_q - NB_W'(1);
          shift_d = step_shift;
          left_d  = step_left;
          if (step_left == '0) begin
            // A whole word is in: check it against the expected framing.
            priority if (fs_q == FS_GAP && step_shift == WORD_IDLE) begin
              fs_d   = FS_GAP_START;
              left_d = LEFT_WORD;
            end else if (fs_q == FS_STX_GAP && step_shift == WORD_IDLE) begin
              fs_d   = FS_STX_GAP_START;
              left_d = LEFT_WORD;
            end else if (fs_q == FS_GAP_START && step_shift == WORD_STX) begin
              fs_d    = FS_STX_PSS;
              shift_d = '0;
              left_d  = LEFT_WORD;
            end else if ((fs_q == FS_STX_GAP_START || fs_q == FS_STX_PSS) &&
                         step_shift == WORD_LF) begin
              fs_d    = FS_LF_PSS;
              shift_d = '0;
              left_d  = LEFT_WORD;
            end else if (fs_q == FS_LF_PSS || fs_q == FS_DATA_PSS) begin
              fs_d    = FS_DATA_PSS;
              shift_d = '0;
              left_d  = LEFT_WORD;
              if (cnt_d != RES_IDX_W'(RES_MAX)) begin
                buf_d[cnt_d] = '{char_code: step_shift[CHAR_W-1:0], kind: KIND_CHAR};
                cnt_d        = cnt_d + RES_IDX_W'(1);
              end
            end else if (fs_q == FS_CR7 && step_shift == WORD_CR) begin
              fs_d    = FS_CR_PSS;
              shift_d = '0;
              left_d  = LEFT_CR_TAIL;
            end else if (fs_q == FS_CR_PSS && step_shift == WORD_ETX) begin
              fs_d    = FS_ETX_P;
              shift_d = '0;
              left_d  = LEFT_ETX;
              if (cnt_d != RES_IDX_W'(RES_MAX)) begin
                buf_d[cnt_d] = '{char_code: '0, kind: KIND_COMPLETE};
                cnt_d        = cnt_d + RES_IDX_W'(1);
              end
            end else begin
              // Unrecognized word: hunt again, keeping the shifted bits.
              fs_d   = FS_UNKNOWN;
              left_d = LEFT_HUNT;
            end
          end else if (step_left == LEFT_CR_PEEK && fs_q == FS_DATA_PSS &&
                       step_shift == WORD_CR_EARLY) begin
            // CR seen early in a data slot: report CR and LF at once.
            fs_d = FS_CR7;
            if (cnt_d != RES_IDX_W'(RES_MAX)) begin
              buf_d[cnt_d] = '{char_code: CHAR_CR, kind: KIND_CHAR};
              cnt_d        = cnt_d + RES_IDX_W'(1);
            end
            if (cnt_d != RES_IDX_W'(RES_MAX)) begin
              buf_d[cnt_d] = '{char_code: CHAR_LF, kind: KIND_CHAR};
              cnt_d        = cnt_d + RES_IDX_W'(1);
            end
          end
        end
      end

      B_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = buf_q[rd_q];
          last_d      = (rd_q == cnt_q - RES_IDX_W'(1));
          if (rd_q == cnt_q - RES_IDX_W'(1)) begin
            rd_d    = '0;
            cnt_d   = '0;
            state_d = B_IDLE;
          end else begin
            rd_d = rd_q + RES_IDX_W'(1);
          end
        end
      end

      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_q.char_code;
  assign kind_o      = out_q.kind;
  assign last_o      = last_q;

endmodule

FILE: sv/run_length_serial_frame_decoder_core.sv
// Top level of the run-length serial frame decoder.
//
// Usage: software writes the bit period (samples per bit) on the configuration
// channel while the block is idle; a period of 0 or 1 turns decoding off and
// input runs are then dropped. cfg_ready_o is always high.
// Each input transfer carries one run: the line level and its length in samples.
// The front end divides the length by the period by repeated subtraction, one
// subtraction per cycle, and stops once the count reaches the gap threshold
// with a period still left; it takes no new run until its command has entered
// the queue. A two-entry queue follows.
// The back end shifts one bit per cycle through the frame state machine, then
// drains its results one at a time, waiting while the receiver stalls.
// The subtract loop sets the input rate unless the back end is slower.
// Each run yields zero to three results; last_o marks the final one of a run.
// When the receiver stalls, the output register holds its result, the back
// end waits, and the queue and then the front end fill and lower in_ready_o.
// Reset clears the bit period to 0, the frame state to unknown, the shift
// register to zero and the bit budget to 255; no results are pending.
module run_length_serial_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlsfd_pkg::PERIOD_W-1:0] cfg_bit_period_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          level_i,
  input  logic [rlsfd_pkg::RUN_W-1:0]   run_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rlsfd_pkg::CHAR_W-1:0]  char_code_o,
  output logic [1:0]                    kind_o,
  output logic                          last_o
);
  import rlsfd_pkg::*;

  logic [PERIOD_W-1:0] bit_period_q;
  logic                fq_valid, fq_ready;
  cmd_t                fq_cmd;
  logic                qb_valid, qb_ready;
  cmd_t                qb_cmd;

  assign cfg_ready_o = 1'b1;

  // Bit period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bit_period_q <= cfg_bit_period_i;
    end
  end

  rlsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bit_period_i (bit_period_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .level_i      (level_i),
    .run_length_i (run_length_i),
    .cmd_valid_o  (fq_valid),
    .cmd_ready_i  (fq_ready),
    .cmd_o        (fq_cmd)
  );

  rlsfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  rlsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule

FILE: sv/rlsfd_checker.sv
// Port-level assertions for the decoder top level, and their bind.
`include "assert_macros.svh"

module rlsfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [rlsfd_pkg::PERIOD_W-1:0] cfg_bit_period_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          level_i,
  input logic [rlsfd_pkg::RUN_W-1:0]   run_length_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rlsfd_pkg::CHAR_W-1:0]  char_code_o,
  input logic [1:0]                    kind_o,
  input logic                          last_o
);
  import rlsfd_pkg::*;

  // Only the three defined result kinds ever appear.
  `ASSERT_CHK(a_kind_defined, out_valid_o |-> (kind_o == KIND_CHAR || kind_o == KIND_RESTART || kind_o == KIND_COMPLETE), "undefined result kind")

  // Markers carry no character code.
  `ASSERT_CHK(a_marker_code_zero, (out_valid_o && kind_o != KIND_CHAR) |-> (char_code_o == '0), "marker result with nonzero code")

  // A restart or a frame completion is always the final result of its run.
  `ASSERT_CHK(a_marker_is_last, (out_valid_o && kind_o != KIND_CHAR) |-> last_o, "marker result not last")

  // A stalled result holds until transferred.
  `ASSERT_CHK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(char_code_o) && $stable(kind_o) && $stable(last_o)), "stalled result changed")

endmodule

bind run_length_serial_frame_decoder_core rlsfd_checker u_rlsfd_checker (.*);
